// ----- rtl/mts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mts_pkg: shared types and constants for the min tracking stack
// Entry width, depth, command and status codes, and the shift control that
// is sent to each stack cell.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VALUE_W     = 32;
  localparam int ENTRY_W     = VALUE_W + 2;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic [CNT_W-1:0]          count_t;

  localparam value_t EMPTY_VALUE = '1;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_POP  = 2'd1,
    CMD_MIN  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage
`default_nettype wire

// ----- rtl/mts_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mts_cell: one stack entry
// Takes the entry above it on a push and the entry below it on a pop.
// ----------------------------------------------------------------------------
module mts_cell (
  input  wire                  clk,
  input  wire mts_pkg::shift_t ctrl,
  input  wire mts_pkg::entry_t push_data,
  input  wire mts_pkg::entry_t pop_data,
  output mts_pkg::entry_t      data
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      data <= push_data;
    end else if (ctrl.pop) begin
      data <= pop_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/min_tracking_stack.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack: LIFO of signed 32-bit values with its current minimum
// Push, pop and get-minimum commands; the minimum is kept encoded in the
// stored entries, so no second stack is needed.
// ----------------------------------------------------------------------------
// One command is taken every cycle and its result appears in the output
// register on the next cycle; while a result waits there under out_stall the
// input is stalled as well. The stack is a row of 256 register cells of
// 34 bits with the top in the first cell; the whole row shifts by one cell
// on a push or a pop, so the top entry is always available without a memory
// read. No clearing pass is needed after reset. Command code 3 is taken and
// gives no result.
module min_tracking_stack (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [1:0]        cmd,
  input  wire signed [31:0] value_in,
  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [31:0] value_out,
  output logic [1:0]        status
);

  mts_pkg::count_t  fill;
  mts_pkg::count_t  fill_next;
  mts_pkg::value_t  cur_min;
  mts_pkg::value_t  cur_min_next;
  mts_pkg::shift_t  ctrl;
  mts_pkg::entry_t  chain [mts_pkg::STACK_DEPTH];
  mts_pkg::entry_t  new_entry;
  mts_pkg::entry_t  val_ext;
  mts_pkg::entry_t  min_ext;
  mts_pkg::entry_t  enc;
  mts_pkg::entry_t  restore;
  mts_pkg::value_t  res_value;
  mts_pkg::status_t res_status;
  logic             res_valid;
  logic             accept;
  logic             empty;
  logic             full;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign empty    = (fill == '0);
  assign full     = (fill == mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH));

  assign val_ext = {{2{value_in[31]}}, value_in};
  assign min_ext = {{2{cur_min[31]}}, cur_min};
  assign enc     = (val_ext <<< 1) - min_ext;
  assign restore = (min_ext <<< 1) - chain[0];

  always_comb begin
    ctrl         = '0;
    fill_next    = fill;
    cur_min_next = cur_min;
    new_entry    = val_ext;
    res_valid    = 1'b0;
    res_value    = cur_min;
    res_status   = mts_pkg::ST_OK;
    if (accept) begin
      unique case (mts_pkg::cmd_t'(cmd))
        mts_pkg::CMD_PUSH: begin
          res_valid = 1'b1;
          if (full) begin
            res_status = mts_pkg::ST_FULL;
          end else begin
            ctrl.push = 1'b1;
            fill_next = fill + mts_pkg::CNT_W'(1);
            if (empty) begin
              cur_min_next = value_in;
            end else if (value_in < cur_min) begin
              new_entry    = enc;
              cur_min_next = value_in;
            end
            res_value = cur_min_next;
          end
        end
        mts_pkg::CMD_POP: begin
          res_valid = 1'b1;
          if (empty) begin
            res_value  = mts_pkg::EMPTY_VALUE;
            res_status = mts_pkg::ST_EMPTY;
          end else begin
            ctrl.pop  = 1'b1;
            fill_next = fill - mts_pkg::CNT_W'(1);
            if (chain[0] < min_ext) begin
              res_value    = cur_min;
              cur_min_next = restore[mts_pkg::VALUE_W-1:0];
            end else begin
              res_value = chain[0][mts_pkg::VALUE_W-1:0];
            end
          end
        end
        mts_pkg::CMD_MIN: begin
          res_valid = 1'b1;
          if (empty) begin
            res_value  = mts_pkg::EMPTY_VALUE;
            res_status = mts_pkg::ST_EMPTY;
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < mts_pkg::STACK_DEPTH; i++) begin : g_cell
    mts_pkg::entry_t push_data;
    mts_pkg::entry_t pop_data;
    if (i == 0) begin : g_top
      assign push_data = new_entry;
    end else begin : g_mid
      assign push_data = chain[i-1];
    end
    if (i == mts_pkg::STACK_DEPTH - 1) begin : g_bot
      assign pop_data = '0;
    end else begin : g_up
      assign pop_data = chain[i+1];
    end
    mts_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .push_data (push_data),
      .pop_data  (pop_data),
      .data      (chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      cur_min   <= '0;
      out_valid <= 1'b0;
    end else begin
      fill    <= fill_next;
      cur_min <= cur_min_next;
      if (res_valid) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      value_out <= res_value;
      status    <= res_status;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= mts_pkg::CNT_W'(mts_pkg::STACK_DEPTH))
    else $error("fill count beyond depth");

  a_push_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.push |=> fill == $past(fill) + mts_pkg::CNT_W'(1))
    else $error("push did not grow the stack");

  a_result_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> out_valid)
    else $error("result beat lost");

  a_empty_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == mts_pkg::ST_EMPTY |-> value_out == mts_pkg::EMPTY_VALUE)
    else $error("empty status without -1");

endmodule
`default_nettype wire
